>>> rtl/core/kts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kts_pkg: shared types, token kind codes and lookup functions
// Kind codes, keyword and punctuation tables, and the token records that pass
// from the front end to the back end of the keyword token scanner.
// ----------------------------------------------------------------------------
package kts_pkg;

  localparam int KW_COUNT      = 6;
  localparam int KW_PREFIX_LEN = 6;
  localparam int PUNCT_COUNT   = 16;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_PTR_W   = 2;

  localparam logic [7:0] CHAR_END = 8'h00;

  localparam logic [4:0] KIND_IDENT      = 5'd0;
  localparam logic [4:0] KIND_INT        = 5'd1;
  localparam logic [4:0] KIND_PUNCT_BASE = 5'd7;
  localparam logic [4:0] KIND_END        = 5'd23;

  // keyword text, index 0 is the first character; unused tail is zero
  localparam logic [0:KW_COUNT-1][0:KW_PREFIX_LEN-1][7:0] KW_TEXT = '{
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
    '{"f", "l", "o", "a", "t", 8'h00},
    '{"d", "o", "u", "b", "l", "e"},
    '{"c", "h", "a", "r", 8'h00, 8'h00},
    '{"s", "t", "r", "i", "n", "g"},
    '{"b", "o", "o", "l", 8'h00, 8'h00}
  };

  localparam logic [0:KW_COUNT-1][2:0] KW_LEN = '{3'd3, 3'd5, 3'd6, 3'd4, 3'd6, 3'd4};

  localparam logic [0:PUNCT_COUNT-1][7:0] PUNCT_CHARS = '{
    "=", ";", "(", ")", "[", "]", "{", "}",
    ">", "<", ",", "!", "+", "-", "*", "/"
  };

  typedef logic [0:KW_PREFIX_LEN-1][7:0] prefix_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] start;
    logic [5:0]  length;
  } token_t;

  // what one character leaves for the back end: one or two tokens
  typedef struct packed {
    token_t first;
    token_t second;
    logic   has_second;
  } token_pair_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] kind;
  } punct_hit_t;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic punct_hit_t punct_lookup(input logic [7:0] c);
    punct_hit_t res;
    res.hit  = 1'b0;
    res.kind = KIND_IDENT;
    for (int k = 0; k < PUNCT_COUNT; k++) begin
      if (c == PUNCT_CHARS[k]) begin
        res.hit  = 1'b1;
        res.kind = KIND_PUNCT_BASE + 5'(k);
      end
    end
    return res;
  endfunction

  // only characters below len are compared: the rest of the prefix may be stale
  function automatic logic [4:0] keyword_kind(input logic [7:0] len, input prefix_t pfx);
    logic [4:0] kind;
    logic       hit;
    kind = KIND_IDENT;
    for (int k = 0; k < KW_COUNT; k++) begin
      hit = (len == 8'(KW_LEN[k]));
      for (int j = 0; j < KW_PREFIX_LEN; j++) begin
        if ((3'(j) < KW_LEN[k]) && (pfx[j] != KW_TEXT[k][j])) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        kind = KIND_INT + 5'(k);
      end
    end
    return kind;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/kts_char_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kts_char_if: character channel
// Valid/ready channel carrying one text byte per request.
// ----------------------------------------------------------------------------
interface kts_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface
`default_nettype wire

>>> rtl/core/kts_token_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kts_token_if: token channel
// Valid/ready channel carrying one token per request.
// ----------------------------------------------------------------------------
interface kts_token_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [31:0] token_start;
  logic [5:0]  token_length;
  logic        last;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output last, input ready);
  modport sink (input valid, input token_kind, input token_start,
                input token_length, input last, output ready);
endinterface
`default_nettype wire

>>> rtl/core/kts_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kts_front: character classifier
// Takes one character per cycle while the queue has room, tracks the pending
// identifier and position, and pushes the tokens it completes into the queue.
// ----------------------------------------------------------------------------
module kts_front #(
  parameter int NAME_BUFFER_SIZE = 64,
  parameter int POSITION_BITS    = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  kts_char_if.sink             chars,
  input  wire logic            q_ready,
  output logic                 push,
  output kts_pkg::token_pair_t push_data
);

  localparam int LEN_W = $clog2(NAME_BUFFER_SIZE);

  logic [LEN_W-1:0]         ident_len, ident_len_next;
  kts_pkg::prefix_t         prefix, prefix_next;
  logic [POSITION_BITS-1:0] ident_start, ident_start_next;
  logic [POSITION_BITS-1:0] char_pos, char_pos_next;

  logic                     accept;
  logic [7:0]               c;
  logic                     have_ident;
  logic [LEN_W-1:0]         len_inc;
  logic                     long_hit;
  kts_pkg::token_t          flush_tok, long_tok, end_tok, punct_tok;
  kts_pkg::punct_hit_t      punct;
  logic                     any_tok;

  assign chars.ready = q_ready;
  assign accept      = chars.valid && q_ready;
  assign c           = chars.char_code;
  assign have_ident  = (ident_len != '0);
  assign len_inc     = ident_len + LEN_W'(1);
  assign long_hit    = (len_inc == LEN_W'(NAME_BUFFER_SIZE - 1));
  assign punct       = kts_pkg::punct_lookup(c);

  always_comb begin
    prefix_next = prefix;
    for (int j = 0; j < kts_pkg::KW_PREFIX_LEN; j++) begin
      if (LEN_W'(j) == ident_len) begin
        prefix_next[j] = c;
      end
    end
  end

  always_comb begin
    flush_tok.kind    = kts_pkg::keyword_kind(8'(ident_len), prefix);
    flush_tok.start   = 32'(ident_start);
    flush_tok.length  = 6'(ident_len);
    // a split run is NAME_BUFFER_SIZE-1 long and is never looked up as a keyword
    long_tok.kind     = kts_pkg::KIND_IDENT;
    long_tok.start    = have_ident ? 32'(ident_start) : 32'(char_pos);
    long_tok.length   = 6'(len_inc);
    end_tok.kind      = kts_pkg::KIND_END;
    end_tok.start     = 32'(char_pos);
    end_tok.length    = 6'd0;
    punct_tok.kind    = punct.kind;
    punct_tok.start   = 32'(char_pos);
    punct_tok.length  = 6'd1;
  end

  always_comb begin
    push_data.first      = end_tok;
    push_data.second     = end_tok;
    push_data.has_second = 1'b0;
    any_tok              = 1'b0;
    ident_len_next       = ident_len;
    ident_start_next     = ident_start;
    char_pos_next        = char_pos + POSITION_BITS'(1);
    priority if (c == kts_pkg::CHAR_END) begin
      any_tok              = 1'b1;
      push_data.first      = have_ident ? flush_tok : end_tok;
      push_data.has_second = have_ident;
      ident_len_next       = '0;
      char_pos_next        = '0;
    end else if (kts_pkg::is_alnum(c)) begin
      any_tok         = long_hit;
      push_data.first = long_tok;
      ident_len_next  = long_hit ? '0 : len_inc;
      if (!have_ident) begin
        ident_start_next = char_pos;
      end
    end else begin
      any_tok              = have_ident || punct.hit;
      push_data.first      = have_ident ? flush_tok : punct_tok;
      push_data.second     = punct_tok;
      push_data.has_second = have_ident && punct.hit;
      ident_len_next       = '0;
    end
  end

  assign push = accept && any_tok;

  always_ff @(posedge clk) begin
    if (rst) begin
      ident_len <= '0;
      char_pos  <= '0;
    end else if (accept) begin
      ident_len <= ident_len_next;
      char_pos  <= char_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ident_start <= ident_start_next;
      prefix      <= prefix_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/kts_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kts_queue: token pair queue
// Short FIFO of token pairs between the classifier and the output stage.
// ----------------------------------------------------------------------------
module kts_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire kts_pkg::token_pair_t push_data,
  output logic                      ready,
  output logic                      pop_valid,
  input  wire logic                 pop,
  output kts_pkg::token_pair_t      pop_data
);

  localparam int CNT_W = kts_pkg::QUEUE_PTR_W + 1;

  kts_pkg::token_pair_t                 slots [kts_pkg::QUEUE_DEPTH];
  logic [kts_pkg::QUEUE_PTR_W-1:0]      wr_ptr, rd_ptr;
  logic [CNT_W-1:0]                     count;

  assign ready     = (count != CNT_W'(kts_pkg::QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    push |-> ready)
    else $error("queue written while full");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> pop_valid)
    else $error("queue read while empty");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count lost a push");

endmodule
`default_nettype wire

>>> rtl/core/kts_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kts_back: token output stage
// Takes token pairs from the queue and sends them one token per request,
// marking the final token of each pair.
// ----------------------------------------------------------------------------
module kts_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_valid,
  input  wire kts_pkg::token_pair_t q_data,
  output logic                      pop,
  kts_token_if.source               tokens
);

  logic            out_valid;
  logic            out_last;
  kts_pkg::token_t out_tok;
  logic            pend_valid;
  kts_pkg::token_t pend_tok;
  logic            advance;

  assign advance = !out_valid || tokens.ready;
  assign pop     = advance && !pend_valid && q_valid;

  assign tokens.valid        = out_valid;
  assign tokens.token_kind   = out_tok.kind;
  assign tokens.token_start  = out_tok.start;
  assign tokens.token_length = out_tok.length;
  assign tokens.last         = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (advance) begin
      priority if (pend_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (q_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= q_data.has_second;
      end else begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (pend_valid) begin
        out_tok  <= pend_tok;
        out_last <= 1'b1;
      end else begin
        out_tok  <= q_data.first;
        out_last <= !q_data.has_second;
        pend_tok <= q_data.second;
      end
    end
  end

  a_pend_needs_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> out_valid)
    else $error("second token waiting without a first on the port");

  a_not_last_has_pend: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |-> pend_valid)
    else $error("non-final token without its partner");

  a_pend_sent_last: assert property (@(posedge clk) disable iff (rst)
    (pend_valid && advance) |=> (out_valid && out_last))
    else $error("second token not marked final");

endmodule
`default_nettype wire

>>> rtl/core/keyword_token_scanner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keyword_token_scanner: streaming keyword and punctuation tokenizer
// One text byte in per request, tokens out with kind, start and length.
// ----------------------------------------------------------------------------
// Usage:
//   chars  : sink of text bytes; byte 0 ends the text and restarts positions.
//   tokens : source of tokens; last marks the final token caused by one byte.
//   Bytes that complete nothing (letters inside an identifier, whitespace with
//   no pending identifier, dropped bytes) give no token.
// Throughput: one byte per cycle while the queue has room. A byte giving two
//   tokens (identifier then punctuation or end) holds the output port for
//   both in turn; the queue takes up the difference.
// Path: a byte's first token is written into a queue slot, then loaded into
//   the output register before it shows on the port.
// Stall: when tokens.ready is low the output register holds; the four-entry
//   queue fills and chars.ready then drops until a slot frees.
// Reset: rst (synchronous) empties queue and output stage and clears the
//   pending identifier and the position counter; no clearing pass.
// Positions wrap modulo 2^POSITION_BITS; token_start shows the low 32 bits.
// ----------------------------------------------------------------------------
module keyword_token_scanner #(
  parameter int NAME_BUFFER_SIZE = 64,
  parameter int POSITION_BITS    = 32
) (
  input  wire logic   clk,
  input  wire logic   rst,
  kts_char_if.sink    chars,
  kts_token_if.source tokens
);

  // front to queue
  logic                 q_push;
  logic                 q_ready;
  kts_pkg::token_pair_t q_in;
  // queue to back
  logic                 q_valid;
  logic                 q_pop;
  kts_pkg::token_pair_t q_out;

  // classifier: identifier tracking, keyword match, punctuation lookup
  kts_front #(
    .NAME_BUFFER_SIZE (NAME_BUFFER_SIZE),
    .POSITION_BITS    (POSITION_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .chars     (chars),
    .q_ready   (q_ready),
    .push      (q_push),
    .push_data (q_in)
  );

  // decouples the byte side from output stalls
  kts_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .ready     (q_ready),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_data  (q_out)
  );

  // serialises token pairs onto the output port
  kts_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_out),
    .pop     (q_pop),
    .tokens  (tokens)
  );

endmodule
`default_nettype wire
